// ----- design/rth_pkg.sv -----
// ----------------------------------------------------------------------------
// rth_pkg
// shared widths, sector codes and constants for the rgb to hsv converter
// ----------------------------------------------------------------------------
`default_nettype none

package rth_pkg;

	// channel and result widths
	localparam int CHANNEL_BITS  = 8;
	localparam int SAT_FRAC_BITS = 16;
	localparam int HUE_BITS      = 9;

	// hue scaled by d before the divide: 60 * t with t < 6 * d
	localparam int HUE_T_BITS   = CHANNEL_BITS + 3;
	localparam int HUE_NUM_BITS = CHANNEL_BITS + HUE_BITS;

	// saturation numerator (2^SAT_FRAC_BITS - 1) * d
	localparam int SAT_NUM_BITS = SAT_FRAC_BITS + CHANNEL_BITS;

	// one quotient bit per divider stage, both divides share the stages
	localparam int DIV_STAGES = (SAT_FRAC_BITS > HUE_BITS) ? SAT_FRAC_BITS : HUE_BITS;

	// sector offsets in units of 60 degrees times d
	localparam int HUE_OFS_GREEN = 2;
	localparam int HUE_OFS_BLUE  = 4;
	localparam int HUE_OFS_WRAP  = 6;

	localparam int HUE_FULL_CIRCLE = 360;

	typedef logic [CHANNEL_BITS-1:0]  chan_t;
	typedef logic [HUE_BITS-1:0]      hue_t;
	typedef logic [SAT_FRAC_BITS-1:0] sat_t;

	// which channel holds the maximum, red before green before blue on ties
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

endpackage

`default_nettype wire

// ----- design/rth_pixel_if.sv -----
// ----------------------------------------------------------------------------
// rth_pixel_if
// valid/ready channel carrying one rgb pixel item
// ----------------------------------------------------------------------------
`default_nettype none

interface rth_pixel_if;

	logic           valid;
	logic           ready;
	rth_pkg::chan_t red;
	rth_pkg::chan_t green;
	rth_pkg::chan_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

`default_nettype wire

// ----- design/rth_hsv_if.sv -----
// ----------------------------------------------------------------------------
// rth_hsv_if
// valid/ready channel carrying one hue, saturation, brightness item
// ----------------------------------------------------------------------------
`default_nettype none

interface rth_hsv_if;

	logic           valid;
	logic           ready;
	rth_pkg::hue_t  hue;
	rth_pkg::sat_t  saturation;
	rth_pkg::chan_t brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink   (input valid, input hue, input saturation, input brightness,
		output ready);

endinterface

`default_nettype wire

// ----- design/rgb_to_hsv_top.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_top
// pipelined rgb to hsv conversion with exact floored hue and saturation
// ----------------------------------------------------------------------------
//
//   channel  | dir | fields                                  | handshake
//   ---------+-----+-----------------------------------------+------------
//   pixel    | in  | red, green, blue (8b each)              | valid/ready
//   hsv      | out | hue (9b), saturation (16b), brightness  | valid/ready
//
// one item per clock sustained while hsv.ready is not holding the pipe; the
// restoring dividers retire one quotient bit per stage for saturation and hue
// side by side
// a single skid register at the input keeps pixel.ready a plain flop, so
// it never depends combinationally on hsv.ready
// on a stall every stage holds; nothing is dropped or repeated
// reset clears only the valid bits and the skid flag
//
`default_nettype none

module rgb_to_hsv_top (
	input  wire            clk,
	input  wire            arst_n,
	rth_pixel_if.sink      pixel,
	rth_hsv_if.source      hsv
);

	localparam int CH  = rth_pkg::CHANNEL_BITS;
	localparam int SB  = rth_pkg::SAT_FRAC_BITS;
	localparam int HB  = rth_pkg::HUE_BITS;
	localparam int TB  = rth_pkg::HUE_T_BITS;
	localparam int HNB = rth_pkg::HUE_NUM_BITS;
	localparam int SNB = rth_pkg::SAT_NUM_BITS;
	localparam int DS  = rth_pkg::DIV_STAGES;

	// ------------------------------------------------------------------
	// global advance and input skid
	// ------------------------------------------------------------------
	logic           en;
	logic           out_v_q;
	logic           skid_full_q;
	rth_pkg::chan_t skid_r_q, skid_g_q, skid_b_q;
	logic           src_v;
	rth_pkg::chan_t src_r, src_g, src_b;

	// the whole pipe moves whenever the output slot is free or being taken
	assign en          = !out_v_q || hsv.ready;
	assign pixel.ready = !skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (en) begin
			skid_full_q <= 1'b0;
		end else if (pixel.valid && !skid_full_q) begin
			skid_full_q <= 1'b1;
		end
	end

	// park the item that arrives while the pipe is stalled
	always_ff @(posedge clk) begin
		if (!en && pixel.valid && !skid_full_q) begin
			skid_r_q <= pixel.red;
			skid_g_q <= pixel.green;
			skid_b_q <= pixel.blue;
		end
	end

	always_comb begin
		if (skid_full_q) begin
			src_v = 1'b1;
			src_r = skid_r_q;
			src_g = skid_g_q;
			src_b = skid_b_q;
		end else begin
			src_v = pixel.valid;
			src_r = pixel.red;
			src_g = pixel.green;
			src_b = pixel.blue;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: max, min and winning sector
	// ------------------------------------------------------------------
	rth_pkg::chan_t   mx_c, mn_c;
	rth_pkg::sector_t sect_c;

	always_comb begin
		mx_c = src_r;
		mn_c = src_r;
		if (src_g > mx_c) mx_c = src_g;
		if (src_b > mx_c) mx_c = src_b;
		if (src_g < mn_c) mn_c = src_g;
		if (src_b < mn_c) mn_c = src_b;
		// red wins ties, then green
		if (src_r == mx_c) begin
			sect_c = rth_pkg::SECT_RED;
		end else if (src_g == mx_c) begin
			sect_c = rth_pkg::SECT_GREEN;
		end else begin
			sect_c = rth_pkg::SECT_BLUE;
		end
	end

	logic             v_s1;
	rth_pkg::chan_t   r_s1, g_s1, b_s1, mx_s1, mn_s1;
	rth_pkg::sector_t sect_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= src_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= src_r;
			g_s1    <= src_g;
			b_s1    <= src_b;
			mx_s1   <= mx_c;
			mn_s1   <= mn_c;
			sect_s1 <= sect_c;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: chroma d and the hue term t, hue = floor(60 * t / d)
	// ------------------------------------------------------------------
	rth_pkg::chan_t d_c;
	logic [TB-1:0]  dx, rx, gx, bx, t_c;

	assign d_c = mx_s1 - mn_s1;
	assign dx  = TB'(d_c);
	assign rx  = TB'(r_s1);
	assign gx  = TB'(g_s1);
	assign bx  = TB'(b_s1);

	// t stays within [0, 6d) in every sector, so modular math is exact
	always_comb begin
		case (sect_s1)
			rth_pkg::SECT_RED: begin
				if (g_s1 >= b_s1) begin
					t_c = gx - bx;
				end else begin
					// negative hue wraps by a full turn
					t_c = dx * TB'(rth_pkg::HUE_OFS_WRAP) + gx - bx;
				end
			end
			rth_pkg::SECT_GREEN: t_c = dx * TB'(rth_pkg::HUE_OFS_GREEN) + bx - rx;
			rth_pkg::SECT_BLUE:  t_c = dx * TB'(rth_pkg::HUE_OFS_BLUE) + rx - gx;
			default:             t_c = '0;
		endcase
	end

	logic           v_s2;
	rth_pkg::chan_t mx_s2, d_s2;
	logic [TB-1:0]  t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2 <= mx_s1;
			d_s2  <= d_c;
			t_s2  <= t_c;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: numerators, split into partial remainder and low bits
	// ------------------------------------------------------------------
	logic [HNB-1:0] hue_num_c;
	logic [SNB-1:0] sat_num_c;

	// 60 * t as 64t - 4t
	assign hue_num_c = (HNB'(t_s2) << 6) - (HNB'(t_s2) << 2);
	// (2^SB - 1) * d as (d << SB) - d
	assign sat_num_c = (SNB'(d_s2) << SB) - SNB'(d_s2);

	logic           v_s3;
	rth_pkg::chan_t mx_s3, d_s3;
	rth_pkg::chan_t sat_rem_s3, hue_rem_s3;
	logic [SB-1:0]  sat_work_s3;
	logic [HB-1:0]  hue_work_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	// quotients fit SB and HB bits, so the top CH bits start below the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s3       <= mx_s2;
			d_s3        <= d_s2;
			sat_rem_s3  <= sat_num_c[SNB-1 -: CH];
			sat_work_s3 <= sat_num_c[SB-1:0];
			hue_rem_s3  <= hue_num_c[HNB-1 -: CH];
			hue_work_s3 <= hue_num_c[HB-1:0];
		end
	end

	// ------------------------------------------------------------------
	// divider stages: one restoring step per stage for saturation, and for hue in the first HB stages
	// the work word shifts numerator bits out and quotient bits in
	// ------------------------------------------------------------------
	logic           v_sd        [DS];
	rth_pkg::chan_t mx_sd       [DS];
	rth_pkg::chan_t d_sd        [DS];
	rth_pkg::chan_t sat_rem_sd  [DS];
	logic [SB-1:0]  sat_work_sd [DS];
	rth_pkg::chan_t hue_rem_sd  [DS];
	logic [HB-1:0]  hue_work_sd [DS];

	for (genvar k = 0; k < DS; k++) begin : g_div
		logic           v_in;
		rth_pkg::chan_t mx_in, d_in, sat_rem_in, hue_rem_in;
		logic [SB-1:0]  sat_work_in;
		logic [HB-1:0]  hue_work_in;
		rth_pkg::chan_t sat_rem_nx, hue_rem_nx;
		logic [SB-1:0]  sat_work_nx;
		logic [HB-1:0]  hue_work_nx;

		if (k == 0) begin : g_first
			assign v_in        = v_s3;
			assign mx_in       = mx_s3;
			assign d_in        = d_s3;
			assign sat_rem_in  = sat_rem_s3;
			assign sat_work_in = sat_work_s3;
			assign hue_rem_in  = hue_rem_s3;
			assign hue_work_in = hue_work_s3;
		end else begin : g_next
			assign v_in        = v_sd[k-1];
			assign mx_in       = mx_sd[k-1];
			assign d_in        = d_sd[k-1];
			assign sat_rem_in  = sat_rem_sd[k-1];
			assign sat_work_in = sat_work_sd[k-1];
			assign hue_rem_in  = hue_rem_sd[k-1];
			assign hue_work_in = hue_work_sd[k-1];
		end

		// saturation divides by the maximum
		if (k < SB) begin : g_sat_step
			logic [CH:0] trial;
			logic        ge;
			assign trial       = {sat_rem_in, sat_work_in[SB-1]};
			assign ge          = trial >= {1'b0, mx_in};
			assign sat_rem_nx  = ge ? CH'(trial - {1'b0, mx_in}) : trial[CH-1:0];
			assign sat_work_nx = {sat_work_in[SB-2:0], ge};
		end else begin : g_sat_hold
			assign sat_rem_nx  = sat_rem_in;
			assign sat_work_nx = sat_work_in;
		end

		// hue divides by the chroma
		if (k < HB) begin : g_hue_step
			logic [CH:0] trial;
			logic        ge;
			assign trial       = {hue_rem_in, hue_work_in[HB-1]};
			assign ge          = trial >= {1'b0, d_in};
			assign hue_rem_nx  = ge ? CH'(trial - {1'b0, d_in}) : trial[CH-1:0];
			assign hue_work_nx = {hue_work_in[HB-2:0], ge};
		end else begin : g_hue_hold
			assign hue_rem_nx  = hue_rem_in;
			assign hue_work_nx = hue_work_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k] <= 1'b0;
			end else if (en) begin
				v_sd[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mx_sd[k]       <= mx_in;
				d_sd[k]        <= d_in;
				sat_rem_sd[k]  <= sat_rem_nx;
				sat_work_sd[k] <= sat_work_nx;
				hue_rem_sd[k]  <= hue_rem_nx;
				hue_work_sd[k] <= hue_work_nx;
			end
		end
	end

	// ------------------------------------------------------------------
	// output register
	// a zero divisor runs the divider to all ones, so black and grey
	// pixels are forced here; the remainders are dropped
	// ------------------------------------------------------------------
	rth_pkg::hue_t  hue_q;
	rth_pkg::sat_t  sat_q;
	rth_pkg::chan_t bright_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_sd[DS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// achromatic pixel: hue is 0
			hue_q    <= (d_sd[DS-1] == '0) ? '0 : hue_work_sd[DS-1];
			// black pixel: saturation is 0
			sat_q    <= (mx_sd[DS-1] == '0) ? '0 : sat_work_sd[DS-1];
			bright_q <= mx_sd[DS-1];
		end
	end

	assign hsv.valid      = out_v_q;
	assign hsv.hue        = hue_q;
	assign hsv.saturation = sat_q;
	assign hsv.brightness = bright_q;

endmodule

`default_nettype wire

// ----- design/rth_checker.sv -----
// ----------------------------------------------------------------------------
// rth_checker
// port-level checks on the rgb to hsv converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rth_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire rth_pkg::hue_t  hue,
	input wire rth_pkg::sat_t  saturation,
	input wire rth_pkg::chan_t brightness
);

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation)
			&& $stable(brightness))
		else $error("stalled hsv item changed");

	// hue stays below a full turn
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue < rth_pkg::hue_t'(rth_pkg::HUE_FULL_CIRCLE))
		else $error("hue out of range");

	// black gives zero hue and saturation
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brightness == '0 |-> hue == '0 && saturation == '0)
		else $error("black pixel with nonzero hue or saturation");

	// zero saturation on a lit pixel means grey, so hue is zero
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturation == '0 |-> hue == '0)
		else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsv_top rth_checker u_rth_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (hsv.valid),
	.out_ready  (hsv.ready),
	.hue        (hsv.hue),
	.saturation (hsv.saturation),
	.brightness (hsv.brightness)
);

`default_nettype wire

// ----- test/tb_rgb_to_hsv_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_top
// self-checking bench for the rgb to hsv converter: pixels are pushed through
// the valid/ready input with random gaps, every returned hsv item is checked
// field by field against an exact integer prediction made at acceptance
// ----------------------------------------------------------------------------

module tb_rgb_to_hsv_top;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 3;
	localparam int DEG_PER_SECTOR = 60;
	localparam int IDLE_PERCENT   = 17;
	// pipeline is 4 + DIV_STAGES deep, give the tail a generous margin
	localparam int DRAIN_CYCLES   = 2 * (4 + rth_pkg::DIV_STAGES);
	// no acceptance on either side for this long means the block is stuck
	localparam int QUIET_LIMIT    = 2000;
	localparam int RANDOM_BATCH   = 615;
	// window of accepted pixels in which neither side idles
	localparam int CALM_FROM      = 700;
	localparam int CALM_TO        = 950;

	typedef struct packed {
		rth_pkg::chan_t red;
		rth_pkg::chan_t green;
		rth_pkg::chan_t blue;
	} pixel_t;

	typedef struct packed {
		rth_pkg::hue_t  hue;
		rth_pkg::sat_t  saturation;
		rth_pkg::chan_t brightness;
	} hsv_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rth_pixel_if pixel ();
	rth_hsv_if   hsv ();

	rgb_to_hsv_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.hsv    (hsv)
	);

	always #HALF_PERIOD clk = ~clk;

	pixel_t pending_pixels[$];   // pixels waiting to be offered
	hsv_t   expected_hsv[$];     // predictions for pixels already taken

	int pix_accepted  = 0;   // bumped at the rising edge that takes a pixel
	int pix_presented = 0;   // pixels the driver has put on the bus
	int mismatches    = 0;
	int quiet_cycles  = 0;

	// both sides run flat out while this window of pixels goes through
	wire calm = (pix_accepted >= CALM_FROM) && (pix_accepted < CALM_TO);

	// exact hsv of one pixel: value is the top channel, saturation and hue
	// are floored rationals, ties on the top channel go red, green, blue
	function automatic hsv_t hsv_of(pixel_t px);
		longint           r, g, b, top, bottom, span, num;
		longint           sat_scale;
		rth_pkg::sector_t sect;
		hsv_t             res;
		r = px.red;
		g = px.green;
		b = px.blue;
		top = r;
		bottom = r;
		if (g > top) top = g;
		if (b > top) top = b;
		if (g < bottom) bottom = g;
		if (b < bottom) bottom = b;
		span = top - bottom;
		sat_scale = (longint'(1) << rth_pkg::SAT_FRAC_BITS) - 1;
		res.brightness = rth_pkg::chan_t'(top);
		res.saturation = '0;
		if (top > 0)
			res.saturation = rth_pkg::sat_t'((sat_scale * span) / top);
		res.hue = '0;
		if (span > 0) begin
			if (r == top)
				sect = rth_pkg::SECT_RED;
			else if (g == top)
				sect = rth_pkg::SECT_GREEN;
			else
				sect = rth_pkg::SECT_BLUE;
			case (sect)
				rth_pkg::SECT_RED: begin
					num = DEG_PER_SECTOR * (g - b);
					// hue below zero wraps into 300..359
					if (num < 0)
						num += rth_pkg::HUE_FULL_CIRCLE * span;
				end
				rth_pkg::SECT_GREEN:
					num = DEG_PER_SECTOR * (rth_pkg::HUE_OFS_GREEN * span + b - r);
				default:
					num = DEG_PER_SECTOR * (rth_pkg::HUE_OFS_BLUE * span + r - g);
			endcase
			res.hue = rth_pkg::hue_t'(num / span);
		end
		return res;
	endfunction

	// random pixel, weighted toward gray, tied maxima, extremes and dark pixels
	function automatic pixel_t random_pixel();
		int             kind;
		int             pick;
		rth_pkg::chan_t lvl;
		rth_pkg::chan_t low;
		pixel_t         px;
		kind = $urandom_range(99);
		px.red   = rth_pkg::chan_t'($urandom);
		px.green = rth_pkg::chan_t'($urandom);
		px.blue  = rth_pkg::chan_t'($urandom);
		if (kind < 10) begin
			// achromatic
			px.green = px.red;
			px.blue  = px.red;
		end else if (kind < 22) begin
			// two channels share the maximum, the third sits at or below it
			lvl  = rth_pkg::chan_t'($urandom);
			low  = rth_pkg::chan_t'($urandom_range(lvl));
			pick = $urandom_range(2);
			case (pick)
				0: px = '{red: lvl, green: lvl, blue: low};
				1: px = '{red: low, green: lvl, blue: lvl};
				default: px = '{red: lvl, green: low, blue: lvl};
			endcase
		end else if (kind < 32) begin
			// each channel at an edge of its range
			px.red   = rth_pkg::chan_t'($urandom_range(1)) ?
				rth_pkg::chan_t'($urandom_range(1)) :
				rth_pkg::chan_t'(254 + $urandom_range(1));
			px.green = rth_pkg::chan_t'($urandom_range(1)) ?
				rth_pkg::chan_t'($urandom_range(1)) :
				rth_pkg::chan_t'(254 + $urandom_range(1));
			px.blue  = rth_pkg::chan_t'($urandom_range(1)) ?
				rth_pkg::chan_t'($urandom_range(1)) :
				rth_pkg::chan_t'(254 + $urandom_range(1));
		end else if (kind < 38) begin
			// very dark pixels, tiny max and tiny spans
			px.red   = rth_pkg::chan_t'($urandom_range(3));
			px.green = rth_pkg::chan_t'($urandom_range(3));
			px.blue  = rth_pkg::chan_t'($urandom_range(3));
		end
		return px;
	endfunction

	// driver: new pixel only once the one on the bus has been taken
	always @(negedge clk) begin
		pixel_t nxt;
		if (!arst_n) begin
			pixel.valid <= 1'b0;
			hsv.ready   <= 1'b0;
		end else begin
			hsv.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
			if (!pixel.valid || pix_accepted == pix_presented) begin
				if (pending_pixels.size() != 0 &&
					(calm || $urandom_range(99) >= IDLE_PERCENT)) begin
					nxt = pending_pixels.pop_front();
					pixel.valid <= 1'b1;
					pixel.red   <= nxt.red;
					pixel.green <= nxt.green;
					pixel.blue  <= nxt.blue;
					pix_presented++;
				end else begin
					pixel.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: predict on pixel acceptance, check on hsv acceptance
	always @(posedge clk) begin
		hsv_t want;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (pixel.valid && pixel.ready) begin
				expected_hsv.push_back(hsv_of('{red: pixel.red, green: pixel.green,
					blue: pixel.blue}));
				pix_accepted++;
				moved = 1'b1;
			end
			if (hsv.valid && hsv.ready) begin
				moved = 1'b1;
				if (expected_hsv.size() == 0) begin
					$display("%0t: unexpected hsv item hue %0d sat %0d val %0d", $time,
						hsv.hue, hsv.saturation, hsv.brightness);
					mismatches++;
				end else begin
					want = expected_hsv.pop_front();
					if (hsv.hue !== want.hue) begin
						$display("%0t: hue expected %0d actual %0d", $time, want.hue,
							hsv.hue);
						mismatches++;
					end
					if (hsv.saturation !== want.saturation) begin
						$display("%0t: saturation expected %0d actual %0d", $time,
							want.saturation, hsv.saturation);
						mismatches++;
					end
					if (hsv.brightness !== want.brightness) begin
						$display("%0t: brightness expected %0d actual %0d", $time,
							want.brightness, hsv.brightness);
						mismatches++;
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: watchdog, no item moved for %0d cycles", $time, QUIET_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		pixel.valid = 1'b0;
		pixel.red   = '0;
		pixel.green = '0;
		pixel.blue  = '0;
		hsv.ready   = 1'b0;

		// directed pixels: black, white, gray, primaries, every tie on the
		// maximum, red-sector hues that wrap, and tiny spans
		pending_pixels.push_back('{red: 8'd0,   green: 8'd0,   blue: 8'd0});
		pending_pixels.push_back('{red: 8'd255, green: 8'd255, blue: 8'd255});
		pending_pixels.push_back('{red: 8'd128, green: 8'd128, blue: 8'd128});
		pending_pixels.push_back('{red: 8'd1,   green: 8'd1,   blue: 8'd1});
		pending_pixels.push_back('{red: 8'd255, green: 8'd0,   blue: 8'd0});
		pending_pixels.push_back('{red: 8'd0,   green: 8'd255, blue: 8'd0});
		pending_pixels.push_back('{red: 8'd0,   green: 8'd0,   blue: 8'd255});
		pending_pixels.push_back('{red: 8'd255, green: 8'd255, blue: 8'd0});
		pending_pixels.push_back('{red: 8'd0,   green: 8'd255, blue: 8'd255});
		pending_pixels.push_back('{red: 8'd255, green: 8'd0,   blue: 8'd255});
		pending_pixels.push_back('{red: 8'd200, green: 8'd200, blue: 8'd200});
		pending_pixels.push_back('{red: 8'd255, green: 8'd0,   blue: 8'd1});
		pending_pixels.push_back('{red: 8'd255, green: 8'd0,   blue: 8'd254});
		pending_pixels.push_back('{red: 8'd255, green: 8'd254, blue: 8'd255});
		pending_pixels.push_back('{red: 8'd1,   green: 8'd0,   blue: 8'd0});
		pending_pixels.push_back('{red: 8'd0,   green: 8'd0,   blue: 8'd1});
		pending_pixels.push_back('{red: 8'd1,   green: 8'd1,   blue: 8'd0});
		pending_pixels.push_back('{red: 8'd255, green: 8'd254, blue: 8'd253});
		pending_pixels.push_back('{red: 8'd200, green: 8'd100, blue: 8'd50});
		pending_pixels.push_back('{red: 8'd100, green: 8'd200, blue: 8'd50});
		pending_pixels.push_back('{red: 8'd50,  green: 8'd100, blue: 8'd200});
		pending_pixels.push_back('{red: 8'd170, green: 8'd85,  blue: 8'd255});
		pending_pixels.push_back('{red: 8'd254, green: 8'd255, blue: 8'd0});

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < RANDOM_BATCH; i++)
			pending_pixels.push_back(random_pixel());

		// hold the sender off until every outstanding hsv item is back
		while (pending_pixels.size() != 0 || pixel.valid || expected_hsv.size() != 0)
			@(negedge clk);
		@(posedge clk);
		for (int i = 0; i < RANDOM_BATCH; i++)
			pending_pixels.push_back(random_pixel());

		// wait for the last pixel to be taken and its result to come back
		while (pending_pixels.size() != 0 || pixel.valid || expected_hsv.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_hsv.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/rth_pkg.sv
design/rth_pixel_if.sv
design/rth_hsv_if.sv
design/rgb_to_hsv_top.sv
design/rth_checker.sv
test/tb_rgb_to_hsv_top.sv
